@@ rtl/sbus_frame_receiver_top_assert.svh @@
// Assertion macros for the checker file.
`ifndef SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBUSRX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBUSRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbusrx_pkg.sv @@
package sbusrx_pkg;

  localparam int FRAME_BYTES     = 25;
  localparam int OUT_CHANNELS    = 18;
  localparam int ANALOG_CHANNELS = 16;
  localparam int FLAG_BYTE       = 23;
  localparam int CH_BITS         = 11;
  localparam int ANALOG_BITS     = ANALOG_CHANNELS * CH_BITS;  // 176
  localparam int FLAG_BITS       = 8;
  localparam int SHREG_BITS      = ANALOG_BITS + FLAG_BITS;    // bytes 1..23
  localparam int ANA_IDX_W       = $clog2(ANALOG_CHANNELS);
  localparam int POS_W           = 5;
  localparam int IDX_W           = 5;
  localparam int TIME_W          = 32;
  localparam int TIMEOUT_W       = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] START_BYTE = 8'h0F;

  // flag byte bits
  localparam int FLAG_DIG0     = 0;
  localparam int FLAG_DIG1     = 1;
  localparam int FLAG_LOST     = 2;
  localparam int FLAG_FAILSAFE = 3;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd3500;
  localparam logic [CH_BITS-1:0]   DIG_LOW_RST  = 11'd173;
  localparam logic [CH_BITS-1:0]   DIG_HIGH_RST = 11'd1812;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TIMEOUT = 2'd0,
    CFG_DIGITAL_LOW   = 2'd1,
    CFG_DIGITAL_HIGH  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] frame_timeout_us;
    logic [CH_BITS-1:0]   digital_low_value;
    logic [CH_BITS-1:0]   digital_high_value;
  } cfg_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0]   flags;
    logic [ANALOG_BITS-1:0] analog;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/sbusrx_front.sv @@
module sbusrx_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbusrx_pkg::cfg_t                     cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  input  logic [sbusrx_pkg::TIME_W-1:0]        in_time_us,
  input  sbusrx_pkg::fifo_stat_t               fifo_stat,
  output logic                                 push,
  output sbusrx_pkg::frame_t                   push_frame
);

  localparam int DW = sbusrx_pkg::SHREG_BITS;
  localparam logic [sbusrx_pkg::POS_W-1:0] POS_FULL  = sbusrx_pkg::POS_W'(sbusrx_pkg::FRAME_BYTES);
  localparam logic [sbusrx_pkg::POS_W-1:0] POS_LAST  =
    sbusrx_pkg::POS_W'(sbusrx_pkg::FRAME_BYTES - 1);
  localparam logic [sbusrx_pkg::POS_W-1:0] POS_FLAG  = sbusrx_pkg::POS_W'(sbusrx_pkg::FLAG_BYTE);
  localparam logic [sbusrx_pkg::POS_W-1:0] POS_FIRST = sbusrx_pkg::POS_W'(1);

  logic [sbusrx_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [sbusrx_pkg::TIME_W-1:0] start_r, start_nxt, elapsed;
  logic [DW-1:0]                 shreg_r, shreg_nxt;
  logic                          timed_out, accept;

  // stall only when the frame queue has no room left
  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;

  assign push_frame.analog = shreg_r[sbusrx_pkg::ANALOG_BITS-1:0];
  assign push_frame.flags  = shreg_r[DW-1:sbusrx_pkg::ANALOG_BITS];

  always_comb begin
    elapsed   = in_time_us - start_r;
    // negative elapsed (bit 31 set) never times out
    timed_out = !elapsed[sbusrx_pkg::TIME_W-1] &&
                (elapsed > {{(sbusrx_pkg::TIME_W-sbusrx_pkg::TIMEOUT_W){1'b0}},
                            cfg.frame_timeout_us});
    pos_eff   = timed_out ? '0 : pos_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    shreg_nxt = shreg_r;
    push      = 1'b0;
    if (accept) begin
      priority if (pos_eff == '0) begin
        if (in_rx_byte == sbusrx_pkg::START_BYTE) begin
          pos_nxt   = POS_FIRST;
          start_nxt = in_time_us;
        end else begin
          pos_nxt = '0;
        end
      end else if (pos_eff < POS_FULL) begin
        pos_nxt = pos_eff + POS_FIRST;
        if (pos_eff <= POS_FLAG) begin
          shreg_nxt = {in_rx_byte, shreg_r[DW-1:8]};
        end
        if (pos_eff == POS_LAST) begin
          push = 1'b1;
        end
      end else begin
        pos_nxt = pos_eff;  // frame done, wait for a timeout
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
  end

endmodule

@@ rtl/sbusrx_frame_fifo.sv @@
module sbusrx_frame_fifo #(
  parameter int DEPTH = sbusrx_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sbusrx_pkg::frame_t     push_frame,
  input  logic                   pop,
  output sbusrx_pkg::frame_t     head,
  output sbusrx_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sbusrx_pkg::frame_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_frame;
    end
  end

endmodule

@@ rtl/sbusrx_back.sv @@
module sbusrx_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbusrx_pkg::cfg_t                     cfg,
  input  sbusrx_pkg::frame_t                   head,
  input  sbusrx_pkg::fifo_stat_t               fifo_stat,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sbusrx_pkg::IDX_W-1:0]         out_channel_index,
  output logic [sbusrx_pkg::CH_BITS-1:0]       out_channel_value,
  output logic                                 out_failsafe,
  output logic                                 out_signal_lost,
  output logic                                 out_last_channel
);

  localparam logic [sbusrx_pkg::IDX_W-1:0] CH_LAST =
    sbusrx_pkg::IDX_W'(sbusrx_pkg::OUT_CHANNELS - 1);
  localparam logic [sbusrx_pkg::IDX_W-1:0] CH_DIG0 =
    sbusrx_pkg::IDX_W'(sbusrx_pkg::ANALOG_CHANNELS);

  logic [sbusrx_pkg::IDX_W-1:0]   ch_r, ch_nxt;
  logic                           valid_r, valid_nxt, load, take, last;
  logic [sbusrx_pkg::CH_BITS-1:0] value;
  logic [sbusrx_pkg::CH_BITS-1:0] value_r;
  logic                           fs_r, lost_r, last_r;

  assign load = !valid_r || out_ready;
  assign take = load && !fifo_stat.empty;
  assign last = (ch_r == CH_LAST);
  assign pop  = take && last;

  always_comb begin
    priority if (ch_r < CH_DIG0) begin
      value = head.analog[ch_r[sbusrx_pkg::ANA_IDX_W-1:0] * sbusrx_pkg::CH_BITS
                          +: sbusrx_pkg::CH_BITS];
    end else if (ch_r == CH_DIG0) begin
      value = head.flags[sbusrx_pkg::FLAG_DIG0] ? cfg.digital_high_value
                                                : cfg.digital_low_value;
    end else begin
      value = head.flags[sbusrx_pkg::FLAG_DIG1] ? cfg.digital_high_value
                                                : cfg.digital_low_value;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    if (load) begin
      valid_nxt = !fifo_stat.empty;
    end
    if (take) begin
      ch_nxt = last ? '0 : ch_r + sbusrx_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ch_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_channel_index <= ch_r;
      value_r           <= value;
      fs_r              <= head.flags[sbusrx_pkg::FLAG_FAILSAFE];
      lost_r            <= !head.flags[sbusrx_pkg::FLAG_FAILSAFE] &&
                           head.flags[sbusrx_pkg::FLAG_LOST];
      last_r            <= last;
    end
  end

  assign out_valid         = valid_r;
  assign out_channel_value = value_r;
  assign out_failsafe      = fs_r;
  assign out_signal_lost   = lost_r;
  assign out_last_channel  = last_r;

endmodule

@@ rtl/sbus_frame_receiver_top.sv @@
// S.BUS frame receiver.
// Input channel (in_valid/in_ready): one received byte plus its microsecond
// arrival time per request. Bytes are taken one per cycle while in_ready is
// high; in_ready drops only while the frame queue holds QUEUE_DEPTH complete
// frames that the back end has not finished unpacking.
// Result channel (out_valid/out_ready): 18 channel requests per frame, index
// 0..17 in order, one per cycle while out_ready is high; out_last_channel
// marks index 17. After the frame's last byte is accepted, the queue write and
// then the output register load come before out_valid rises; the back end
// refills its single output register with one result per cycle while
// out_ready is high.
// Config port: cfg_we/cfg_index/cfg_wdata writes timeout, digital low and
// digital high values; other indexes are ignored.
// Reset (rst_n low, synchronous): byte position and frame start time go to
// zero, registers to 3500 us / 173 / 1812, queue and output empty.
// A stalled receiver holds the current result; the front keeps taking bytes
// until the queue fills, then holds in_ready low.
module sbus_frame_receiver_top #(
  parameter int QUEUE_DEPTH = sbusrx_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [sbusrx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbusrx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // byte input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  input  logic [sbusrx_pkg::TIME_W-1:0]        in_time_us,
  // channel results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sbusrx_pkg::IDX_W-1:0]         out_channel_index,
  output logic [sbusrx_pkg::CH_BITS-1:0]       out_channel_value,
  output logic                                 out_failsafe,
  output logic                                 out_signal_lost,
  output logic                                 out_last_channel
);

  sbusrx_pkg::cfg_t       cfg_r, cfg_nxt;
  sbusrx_pkg::frame_t     push_frame, head;
  sbusrx_pkg::fifo_stat_t fifo_stat;
  logic                   push, pop;

  // config registers; the user must write them only while the block is idle, which the block does not enforce
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sbusrx_pkg::CFG_FRAME_TIMEOUT:
          cfg_nxt.frame_timeout_us = cfg_wdata[sbusrx_pkg::TIMEOUT_W-1:0];
        sbusrx_pkg::CFG_DIGITAL_LOW:
          cfg_nxt.digital_low_value = cfg_wdata[sbusrx_pkg::CH_BITS-1:0];
        sbusrx_pkg::CFG_DIGITAL_HIGH:
          cfg_nxt.digital_high_value = cfg_wdata[sbusrx_pkg::CH_BITS-1:0];
        default: cfg_nxt = cfg_r;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_timeout_us   <= sbusrx_pkg::TIMEOUT_RST;
      cfg_r.digital_low_value  <= sbusrx_pkg::DIG_LOW_RST;
      cfg_r.digital_high_value <= sbusrx_pkg::DIG_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: timeout, start-byte hunt, byte collection
  sbusrx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .in_time_us (in_time_us),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  // complete frames waiting for the back end
  sbusrx_frame_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  // back: unpack channels, one result per cycle while out_ready is high
  sbusrx_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .fifo_stat         (fifo_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_failsafe      (out_failsafe),
    .out_signal_lost   (out_signal_lost),
    .out_last_channel  (out_last_channel)
  );

endmodule

@@ rtl/sbusrx_checker.sv @@
`include "sbus_frame_receiver_top_assert.svh"

module sbusrx_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [sbusrx_pkg::IDX_W-1:0]       out_channel_index,
  input logic [sbusrx_pkg::CH_BITS-1:0]     out_channel_value,
  input logic                               out_failsafe,
  input logic                               out_signal_lost,
  input logic                               out_last_channel
);

  localparam logic [sbusrx_pkg::IDX_W-1:0] CH_LAST =
    sbusrx_pkg::IDX_W'(sbusrx_pkg::OUT_CHANNELS - 1);

  // expected index of the next result
  logic [sbusrx_pkg::IDX_W-1:0] exp_r, exp_nxt;

  always_comb begin
    exp_nxt = exp_r;
    if (out_valid && out_ready) begin
      exp_nxt = (out_channel_index == CH_LAST) ? '0
                                               : out_channel_index + sbusrx_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else begin
      exp_r <= exp_nxt;
    end
  end

  `SBUSRX_ASSERT_NOW(a_index_order, out_valid, out_channel_index == exp_r,
                     "channel results out of order")
  `SBUSRX_ASSERT_NOW(a_last_flag, out_valid, out_last_channel == (out_channel_index == CH_LAST),
                     "last_channel does not match channel 17")
  `SBUSRX_ASSERT_NOW(a_flags_excl, out_valid && out_failsafe, !out_signal_lost,
                     "signal_lost set together with failsafe")
  `SBUSRX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(out_channel_index) && $stable(out_channel_value),
                      "stalled result changed")

endmodule

bind sbus_frame_receiver_top sbusrx_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_failsafe      (out_failsafe),
  .out_signal_lost   (out_signal_lost),
  .out_last_channel  (out_last_channel)
);
